>>> hdl/tbtf_pkg.sv
// Shared types, codes and helpers for the triple-buffer telemetry framer.
// No dependencies; imported by the channel interfaces, the frame store and the top level.
package tbtf_pkg;

    localparam int TBTF_CHANNELS = 8;
    localparam int NSLOTS        = 3;

    typedef logic [31:0] t_word;
    typedef logic [1:0]  t_slot;
    typedef logic [1:0]  t_status;
    typedef logic [3:0]  t_outcome;
    typedef logic [1:0]  t_req;
    typedef logic [NSLOTS-1:0][1:0] t_status_vec;

    localparam t_word TAIL_WORD = 32'h7F80_0000;

    // slot status codes
    localparam t_status ST_IDLE    = 2'd0;
    localparam t_status ST_PENDING = 2'd1;
    localparam t_status ST_ACTIVE  = 2'd2;

    // request codes
    localparam t_req REQ_SET  = 2'd0;
    localparam t_req REQ_SEND = 2'd1;
    localparam t_req REQ_DONE = 2'd2;
    localparam t_req REQ_ERR  = 2'd3;

    // transmitter start status
    localparam logic [1:0] START_OK   = 2'd0;
    localparam logic [1:0] START_BUSY = 2'd1;

    // error reasons
    localparam logic [1:0] ERR_RX_STALL = 2'd0;
    localparam logic [1:0] ERR_ABORT    = 2'd1;

    // outcome codes
    localparam t_outcome OC_WRITTEN    = 4'd0;
    localparam t_outcome OC_IGNORED    = 4'd1;
    localparam t_outcome OC_STARTED    = 4'd2;
    localparam t_outcome OC_QUEUED     = 4'd3;
    localparam t_outcome OC_DROPPED    = 4'd4;
    localparam t_outcome OC_RECLAIMED  = 4'd5;
    localparam t_outcome OC_STARTFAIL  = 4'd6;
    localparam t_outcome OC_DONE       = 4'd7;
    localparam t_outcome OC_RELEASED   = 4'd8;
    localparam t_outcome OC_ERRIGNORED = 4'd9;

    // true when some slot is active
    function automatic logic any_active(t_status_vec s);
        logic r;
        r = 1'b0;
        for (int i = 0; i < NSLOTS; i++) begin
            if (s[i] == ST_ACTIVE) r = 1'b1;
        end
        return r;
    endfunction

    // true when no slot is idle
    function automatic logic none_idle(t_status_vec s);
        logic r;
        r = 1'b1;
        for (int i = 0; i < NSLOTS; i++) begin
            if (s[i] == ST_IDLE) r = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> hdl/tbtf_if.sv
// Valid/ready channel interfaces for request words and result words.
// Depends on tbtf_pkg for the field types.
interface tbtf_in_if;
    import tbtf_pkg::*;

    logic        valid;
    logic        ready;
    t_req        req_type;
    logic [7:0]  channel;
    t_word       value;
    t_word       stamp;
    logic [1:0]  start_status;
    logic [1:0]  error_reason;
    logic        tx_idle;

    modport source (output valid, req_type, channel, value, stamp, start_status,
                    error_reason, tx_idle, input ready);
    modport sink   (input valid, req_type, channel, value, stamp, start_status,
                    error_reason, tx_idle, output ready);
endinterface

interface tbtf_out_if;
    import tbtf_pkg::*;

    logic      valid;
    logic      ready;
    t_word     frame_word;
    logic      word_valid;
    logic      last;
    t_slot     slot;
    t_outcome  outcome;
    logic      no_idle_slot;
    t_word     reclaim_count;

    modport source (output valid, frame_word, word_valid, last, slot, outcome,
                    no_idle_slot, reclaim_count, input ready);
    modport sink   (input valid, frame_word, word_valid, last, slot, outcome,
                    no_idle_slot, reclaim_count, output ready);
endinterface

>>> hdl/triple_buffer_telemetry_framer.sv
// Triple-buffer telemetry framer top level: slot bookkeeping and frame sequencer.
// Depends on tbtf_pkg, tbtf_in_if/tbtf_out_if and tbtf_store.
//
// Usage:
//   i_in carries request words (set channel, send frame, transmit complete,
//   transmit error); o_out carries result words. A word moves when valid and
//   ready are both high. Requests are handled one at a time.
//   Every request except a started frame gives one result word, registered
//   in the cycle after the request is taken; with o_out.ready high such requests
//   can be taken every cycle.
//   A started frame gives CHANNELS+2 words (stamp, channel values, tail
//   0x7F800000). The first word passes the store read register, then the
//   output register; then one word per cycle while o_out.ready is high, paced
//   by the single read port of the frame store; next requests wait for the tail.
//   Reset (synchronous, active low) sets all slots idle, write and active slot
//   to 0, the reclaim count to 0, and makes the whole store read as zero at
//   once (no clearing pass).
//   When the receiver stalls, the output register holds its word, frame reads
//   pause, and no new request is taken until the pending result has moved.
module triple_buffer_telemetry_framer #(
    parameter int CHANNELS = tbtf_pkg::TBTF_CHANNELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tbtf_in_if.sink     i_in,
    tbtf_out_if.source  o_out
);
    import tbtf_pkg::*;

    localparam int W     = CHANNELS + 1;
    localparam int DEPTH = NSLOTS * W;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(W + 1);
    localparam logic [AW-1:0] BASE1 = AW'(W);
    localparam logic [AW-1:0] BASE2 = AW'(2 * W);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EMIT = 1'b1;

    // control state
    logic         r_state;
    t_status_vec  r_status;
    t_slot        r_wslot;
    t_slot        r_aslot;
    t_word        r_reclaims;
    t_slot        r_emit_slot;
    logic         r_emit_noidle;
    logic [CW-1:0] r_rd_cnt;
    logic         r_rd_vld;

    // output register
    logic         r_o_valid;
    t_word        r_o_word;
    logic         r_o_wvalid;
    logic         r_o_last;
    t_slot        r_o_slot;
    t_outcome     r_o_outcome;
    logic         r_o_noidle;
    t_word        r_o_reclaims;

    // request decode
    t_status_vec  n_status;
    t_slot        n_wslot;
    t_slot        n_aslot;
    t_word        n_reclaims;
    logic         mem_we;
    logic [AW-1:0] mem_waddr;
    t_word        mem_wdata;
    logic         go_emit;
    t_slot        e_slot;
    logic         e_noidle;
    t_slot        res_slot;
    t_outcome     res_outcome;
    logic         res_noidle;
    logic [AW-1:0] wbase;
    logic         found;
    t_slot        pidx;

    // frame sequencer
    logic         acc;
    logic         out_free;
    logic         move;
    logic         issue;
    logic         tail;
    logic [AW-1:0] rbase;
    logic [AW-1:0] mem_raddr;
    t_word        mem_rdata;
    logic [NSLOTS-1:0] act_vec;

    assign out_free   = !r_o_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && out_free;
    assign acc        = i_in.valid && i_in.ready;

    // slot base address in the store
    function automatic logic [AW-1:0] base_of(t_slot s);
        logic [AW-1:0] b;
        case (s)
            2'd1:    b = BASE1;
            2'd2:    b = BASE2;
            default: b = '0;
        endcase
        return b;
    endfunction

    assign wbase = base_of(r_wslot);

    // request handling on the current slot state
    always_comb begin
        n_status    = r_status;
        n_wslot     = r_wslot;
        n_aslot     = r_aslot;
        n_reclaims  = r_reclaims;
        mem_we      = 1'b0;
        mem_waddr   = wbase;
        mem_wdata   = i_in.value;
        go_emit     = 1'b0;
        e_slot      = r_wslot;
        e_noidle    = 1'b0;
        res_slot    = r_wslot;
        res_outcome = OC_IGNORED;
        res_noidle  = 1'b0;
        found       = 1'b0;
        pidx        = '0;
        case (i_in.req_type)
            REQ_SET: begin
                if ((i_in.channel != 8'd0) && (i_in.channel <= 8'(CHANNELS)) &&
                    (r_status[r_wslot] == ST_IDLE)) begin
                    mem_we      = 1'b1;
                    mem_waddr   = wbase + AW'(i_in.channel);
                    res_outcome = OC_WRITTEN;
                end
            end
            REQ_SEND: begin
                if (r_status[r_wslot] != ST_IDLE) begin
                    res_outcome = OC_DROPPED;
                    if ((r_status[r_wslot] == ST_PENDING) && !any_active(r_status)) begin
                        n_status[r_wslot] = ST_IDLE;
                        n_reclaims        = r_reclaims + 32'd1;
                        res_outcome       = OC_RECLAIMED;
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = i_in.stamp;
                    if (any_active(r_status)) begin
                        n_status[r_wslot] = ST_PENDING;
                        res_outcome       = OC_QUEUED;
                    end else begin
                        case (i_in.start_status)
                            START_OK: begin
                                n_status[r_wslot] = ST_ACTIVE;
                                n_aslot           = r_wslot;
                                res_outcome       = OC_STARTED;
                                go_emit           = 1'b1;
                            end
                            START_BUSY: begin
                                n_status[r_wslot] = ST_PENDING;
                                res_outcome       = OC_QUEUED;
                            end
                            default: begin
                                n_status[r_wslot] = ST_IDLE;
                                res_outcome       = OC_STARTFAIL;
                            end
                        endcase
                    end
                    // lowest idle slot becomes the write slot
                    for (int i = NSLOTS - 1; i >= 0; i--) begin
                        if (n_status[i] == ST_IDLE) n_wslot = t_slot'(i);
                    end
                end
                res_noidle = none_idle(n_status);
                e_noidle   = res_noidle;
            end
            REQ_DONE: begin
                n_status[r_aslot] = ST_IDLE;
                for (int i = NSLOTS - 1; i >= 0; i--) begin
                    if (n_status[i] == ST_PENDING) begin
                        found = 1'b1;
                        pidx  = t_slot'(i);
                    end
                end
                if (found) begin
                    res_slot = pidx;
                    if (i_in.start_status == START_OK) begin
                        n_status[pidx] = ST_ACTIVE;
                        n_aslot        = pidx;
                        go_emit        = 1'b1;
                        e_slot         = pidx;
                    end else begin
                        n_status[pidx] = ST_IDLE;
                        res_outcome    = OC_STARTFAIL;
                    end
                end else begin
                    res_slot    = r_aslot;
                    res_outcome = OC_DONE;
                end
            end
            REQ_ERR: begin
                res_slot    = r_aslot;
                res_outcome = OC_ERRIGNORED;
                if ((i_in.error_reason != ERR_RX_STALL) &&
                    (r_status[r_aslot] == ST_ACTIVE) &&
                    ((i_in.error_reason == ERR_ABORT) || i_in.tx_idle)) begin
                    n_status[r_aslot] = ST_IDLE;
                    res_outcome       = OC_RELEASED;
                end
            end
            default: begin
                res_outcome = OC_ERRIGNORED;
            end
        endcase
    end

    // frame read pipeline: store read register is the middle stage
    assign rbase     = base_of(r_emit_slot);
    assign mem_raddr = rbase + AW'(r_rd_cnt);
    assign move      = (r_state == S_EMIT) && r_rd_vld && out_free;
    assign issue     = (r_state == S_EMIT) && (r_rd_cnt < CW'(W)) && (!r_rd_vld || move);
    assign tail      = (r_state == S_EMIT) && (r_rd_cnt == CW'(W)) && !r_rd_vld && out_free;

    tbtf_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (acc && mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (issue),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // slot bookkeeping and sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_status   <= '0;
            r_wslot    <= '0;
            r_aslot    <= '0;
            r_reclaims <= '0;
            r_rd_cnt   <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (acc) begin
                r_status   <= n_status;
                r_wslot    <= n_wslot;
                r_aslot    <= n_aslot;
                r_reclaims <= n_reclaims;
                if (go_emit) begin
                    r_state  <= S_EMIT;
                    r_rd_cnt <= '0;
                    r_rd_vld <= 1'b0;
                end
            end
            if (issue) begin
                r_rd_cnt <= r_rd_cnt + CW'(1);
                r_rd_vld <= 1'b1;
            end else if (move) begin
                r_rd_vld <= 1'b0;
            end
            if (tail) begin
                r_state <= S_IDLE;
            end
        end
    end

    // frame attributes, held for the whole frame
    always_ff @(posedge i_clk) begin
        if (acc && go_emit) begin
            r_emit_slot   <= e_slot;
            r_emit_noidle <= e_noidle;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((acc && !go_emit) || move || tail) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (acc && !go_emit) begin
            r_o_word     <= '0;
            r_o_wvalid   <= 1'b0;
            r_o_last     <= 1'b1;
            r_o_slot     <= res_slot;
            r_o_outcome  <= res_outcome;
            r_o_noidle   <= res_noidle;
            r_o_reclaims <= n_reclaims;
        end else if (move || tail) begin
            r_o_word     <= tail ? TAIL_WORD : mem_rdata;
            r_o_wvalid   <= 1'b1;
            r_o_last     <= tail;
            r_o_slot     <= r_emit_slot;
            r_o_outcome  <= OC_STARTED;
            r_o_noidle   <= r_emit_noidle;
            r_o_reclaims <= r_reclaims;
        end
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.frame_word    = r_o_word;
    assign o_out.word_valid    = r_o_wvalid;
    assign o_out.last          = r_o_last;
    assign o_out.slot          = r_o_slot;
    assign o_out.outcome       = r_o_outcome;
    assign o_out.no_idle_slot  = r_o_noidle;
    assign o_out.reclaim_count = r_o_reclaims;

    always_comb begin
        for (int i = 0; i < NSLOTS; i++) begin
            act_vec[i] = (r_status[i] == ST_ACTIVE);
        end
    end

    a_one_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(act_vec))
        else $error("more than one active slot");

    a_emit_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_status[r_emit_slot] == ST_ACTIVE))
        else $error("emitting a slot that is not active");

    a_rd_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_cnt <= CW'(W))
        else $error("frame read count overrun");

    a_word_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_wvalid) |-> (r_o_outcome == OC_STARTED))
        else $error("frame word without started outcome");

    a_no_take_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !i_in.ready)
        else $error("request taken during frame");

endmodule

>>> hdl/tbtf_store.sv
// Frame store: one write port, one registered read port, per-entry valid bits.
// Entries never written read as zero. Depends on tbtf_pkg for the word type.
module tbtf_store #(
    parameter int DEPTH = 3 * (tbtf_pkg::TBTF_CHANNELS + 1),
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  tbtf_pkg::t_word      i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output tbtf_pkg::t_word      o_rdata
);
    import tbtf_pkg::*;

    t_word            r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    t_word            r_rdata;

    // data array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // written marks, cleared at reset so the store reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // registered read, holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : '0;
        end
    end

    assign o_rdata = r_rdata;

    a_raddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_re |-> (i_raddr < DEPTH))
        else $error("frame store read address out of range");

    a_waddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_we |-> (i_waddr < DEPTH))
        else $error("frame store write address out of range");

    a_mark_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_we |=> r_valid[$past(i_waddr)])
        else $error("written entry not marked");

endmodule
